>>> rtl/pts_pkg.sv
// Shared types and constants for the periodic task scheduler.
// No dependencies; imported by every scheduler module.
package pts_pkg;

   localparam int NUM_SLOTS   = 16;
   localparam int SLOT_WIDTH  = $clog2(NUM_SLOTS);
   localparam int COUNT_WIDTH = 16;
   localparam int TIME_WIDTH  = 32;

   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_ADD      = 3'd1,
      CMD_REMOVE   = 3'd2,
      CMD_DISPATCH = 3'd3,
      CMD_SET_TIME = 3'd4
   } cmd_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;  // capture request beat
      logic exec;  // apply captured command, register result
   } ctrl_type;

endpackage

>>> rtl/pts_ctrl.sv
// Controller state machine for the periodic task scheduler.
// Depends on pts_pkg.
module pts_ctrl
   import pts_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   output ctrl_type ctrl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            state_in = start ? ST_EXEC : ST_IDLE;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy      = 1'b0;
      ctrl.load = 1'b0;
      ctrl.exec = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ctrl.load = start;
         end
         ST_EXEC: begin
            busy      = 1'b1;
            ctrl.exec = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

>>> rtl/pts_datapath.sv
// Slot table, scan pointer, time counter and result registers.
// Depends on pts_pkg; driven by pts_ctrl through ctrl_type.
module pts_datapath
   import pts_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_type               ctrl,
   input  logic [2:0]             req_cmd,
   input  logic [SLOT_WIDTH-1:0]  req_task_slot,
   input  logic [COUNT_WIDTH-1:0] req_first_delay,
   input  logic [COUNT_WIDTH-1:0] req_reload_period,
   input  logic [TIME_WIDTH-1:0]  req_time_load,
   output logic                   rsp_valid,
   output logic                   rsp_accepted,
   output logic                   rsp_dispatch_valid,
   output logic [SLOT_WIDTH-1:0]  rsp_dispatch_slot,
   output logic [TIME_WIDTH-1:0]  rsp_time_now
);

   // lowest set bit of a slot vector
   function automatic logic [SLOT_WIDTH-1:0] first_set(input logic [NUM_SLOTS-1:0] v);
      logic [SLOT_WIDTH-1:0] idx;
      idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = SLOT_WIDTH'(i);
         end
      end
      return idx;
   endfunction

   // captured request beat
   cmd_type                cmd_ff;
   logic [SLOT_WIDTH-1:0]  slot_ff;
   logic [COUNT_WIDTH-1:0] delay_ff;
   logic [COUNT_WIDTH-1:0] period_ld_ff;
   logic [TIME_WIDTH-1:0]  tload_ff;

   // slot table and global state
   logic [NUM_SLOTS-1:0]   active_ff, active_in;
   logic [NUM_SLOTS-1:0]   ready_ff, ready_in;
   logic [COUNT_WIDTH-1:0] count_ff [NUM_SLOTS];
   logic [COUNT_WIDTH-1:0] count_in [NUM_SLOTS];
   logic [COUNT_WIDTH-1:0] period_ff [NUM_SLOTS];
   logic [COUNT_WIDTH-1:0] period_in [NUM_SLOTS];
   logic [SLOT_WIDTH-1:0]  ptr_ff, ptr_in;
   logic [TIME_WIDTH-1:0]  time_ff, time_in;

   // result registers
   logic                   valid_ff;
   logic                   acc_ff, acc_in;
   logic                   dv_ff, dv_in;
   logic [SLOT_WIDTH-1:0]  ds_ff, ds_in;
   logic [TIME_WIDTH-1:0]  now_ff;

   // round-robin pick
   logic [NUM_SLOTS-1:0]   pending;
   logic [NUM_SLOTS-1:0]   upper;
   logic [SLOT_WIDTH-1:0]  pick;

   always_comb begin
      pending = active_ff & ready_ff;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         upper[i] = pending[i] && (SLOT_WIDTH'(i) >= ptr_ff);
      end
      pick = (|upper) ? first_set(upper) : first_set(pending);
   end

   always_comb begin
      active_in = active_ff;
      ready_in  = ready_ff;
      count_in  = count_ff;
      period_in = period_ff;
      ptr_in    = ptr_ff;
      time_in   = time_ff;
      acc_in    = 1'b0;
      dv_in     = 1'b0;
      ds_in     = '0;
      if (ctrl.exec) begin
         case (cmd_ff)
            CMD_TICK: begin
               time_in = time_ff + 1'b1;
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (active_ff[i]) begin
                     if (count_ff[i] == '0) begin
                        ready_in[i] = 1'b1;
                        count_in[i] = period_ff[i];
                     end else begin
                        count_in[i] = count_ff[i] - 1'b1;
                     end
                  end
               end
            end
            CMD_ADD: begin
               if (!active_ff[slot_ff]) begin
                  active_in[slot_ff] = 1'b1;
                  ready_in[slot_ff]  = 1'b0;
                  count_in[slot_ff]  = delay_ff;
                  period_in[slot_ff] = period_ld_ff;
                  acc_in             = 1'b1;
               end
            end
            CMD_REMOVE: begin
               if (active_ff[slot_ff]) begin
                  active_in[slot_ff] = 1'b0;
                  ready_in[slot_ff]  = 1'b0;
                  acc_in             = 1'b1;
               end
            end
            CMD_DISPATCH: begin
               if (|pending) begin
                  ready_in[pick] = 1'b0;
                  if (period_ff[pick] == '0) begin
                     active_in[pick] = 1'b0;  // one-shot retires
                  end
                  dv_in  = 1'b1;
                  ds_in  = pick;
                  ptr_in = (pick == SLOT_WIDTH'(NUM_SLOTS - 1)) ? '0 : pick + 1'b1;
               end
            end
            CMD_SET_TIME: begin
               time_in = tload_ff;
            end
            default: begin
               time_in = time_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff       <= cmd_type'(req_cmd);
         slot_ff      <= req_task_slot;
         delay_ff     <= req_first_delay;
         period_ld_ff <= req_reload_period;
         tload_ff     <= req_time_load;
      end
      count_ff  <= count_in;
      period_ff <= period_in;
      if (ctrl.exec) begin
         acc_ff <= acc_in;
         dv_ff  <= dv_in;
         ds_ff  <= ds_in;
         now_ff <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         ready_ff  <= '0;
         ptr_ff    <= '0;
         time_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         ready_ff  <= ready_in;
         ptr_ff    <= ptr_in;
         time_ff   <= time_in;
         valid_ff  <= ctrl.exec;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_accepted       = acc_ff;
   assign rsp_dispatch_valid = dv_ff;
   assign rsp_dispatch_slot  = ds_ff;
   assign rsp_time_now       = now_ff;

endmodule

>>> rtl/periodic_task_scheduler_top.sv
// Periodic task scheduler: top level joining controller and datapath.
// Depends on pts_pkg, pts_ctrl and pts_datapath.
// The start beat is captured in idle, applied in the execute state and
// registered into the result strobe. No new command is taken while busy;
// busy is high for the single execute cycle of each command.
// The receiver cannot stall: rsp_valid pulses for exactly one cycle.
// Synchronous active-high reset clears slot marks, scan pointer and time.
module periodic_task_scheduler_top
   import pts_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [2:0]             req_cmd,
   input  logic [SLOT_WIDTH-1:0]  req_task_slot,
   input  logic [COUNT_WIDTH-1:0] req_first_delay,
   input  logic [COUNT_WIDTH-1:0] req_reload_period,
   input  logic [TIME_WIDTH-1:0]  req_time_load,
   output logic                   rsp_valid,
   output logic                   rsp_accepted,
   output logic                   rsp_dispatch_valid,
   output logic [SLOT_WIDTH-1:0]  rsp_dispatch_slot,
   output logic [TIME_WIDTH-1:0]  rsp_time_now
);

   ctrl_type ctrl;

   // Controller: idle -> execute -> idle; a beat is taken in idle.
   pts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   // Datapath: all active slot countdowns step in parallel on a tick; dispatch
   // uses a rotated priority pick starting at the scan pointer.
   pts_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .req_cmd            (req_cmd),
      .req_task_slot      (req_task_slot),
      .req_first_delay    (req_first_delay),
      .req_reload_period  (req_reload_period),
      .req_time_load      (req_time_load),
      .rsp_valid          (rsp_valid),
      .rsp_accepted       (rsp_accepted),
      .rsp_dispatch_valid (rsp_dispatch_valid),
      .rsp_dispatch_slot  (rsp_dispatch_slot),
      .rsp_time_now       (rsp_time_now)
   );

endmodule
